/* rtl/bmcd_pkg.sv */
// ----------------------------------------------------------------------------
// bmcd_pkg: shared definitions for the button multi-click detector
// Widths, edge-history depth and the cell control group.
// ----------------------------------------------------------------------------
package bmcd_pkg;

   localparam int TIME_W        = 32;
   localparam int SPAN_W        = 16;
   localparam int COUNT_W       = 16;
   localparam int MAX_CLICKS    = 5;
   // Deepest look-back is 2*MAX_CLICKS-1 button transitions; older history never matters.
   localparam int EDGE_CELLS    = 2 * MAX_CLICKS - 1;

   typedef struct packed {
      logic shift;   // new edge: head loads now, rest take neighbor's time
      logic clear;   // clear request: history emptied
   } cell_ctl_type;

endpackage

/* rtl/button_multi_click_detector.sv */
// ----------------------------------------------------------------------------
// button_multi_click_detector: counts presses and flags 1..5-click sequences
// Edge times shift down a row of cells; taps 1,3,5,7,9 transitions back are checked
// against the span window on every level change.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  req_     in   req_tvalid/tready     tuser: cmd; tdata: line_value, now_ms
//  rsp_     out  rsp_tvalid/tready     tdata: level_now, click_flags,
//                                             press_count, hold_ms
//  csr_     in   csr_valid/ready       csr_data: span_ms
//
//  One request per cycle; its response appears in the output register the
//  cycle after acceptance. Throughput is set by the single response register:
//  a new request is taken whenever that register is empty or being drained.
//  Synchronous active-high reset empties the history, clears flags, count,
//  level and change time, and loads span_ms = 400.
//  A stalled rsp_tready holds the response and back-pressures req_tready.
//  csr_ready is always high; write only while idle.
//
module button_multi_click_detector (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] cmd (1 = clear history and flags)
   input  logic [39:0] req_tdata,   // [1:0] line_value, [33:2] now_ms, rest zero
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [1:0] level_now, [6:2] click_flags,
                                    // [22:7] press_count, [54:23] hold_ms, [55] 0
   // span register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // span_ms
);

   localparam int TW = bmcd_pkg::TIME_W;
   localparam int NC = bmcd_pkg::MAX_CLICKS;
   localparam int NE = bmcd_pkg::EDGE_CELLS;

   typedef enum logic [1:0] {LVL_LOW, LVL_HIGH, LVL_ERR} level_type;

   // ---- request decode
   logic           req_fire;
   logic           clr_cmd;
   logic [1:0]     line_value;
   logic [TW-1:0]  now_ms;
   level_type      level_cls;
   logic           edge_seen;

   assign req_fire   = req_tvalid && req_tready;
   assign clr_cmd    = req_tuser[0];
   assign line_value = req_tdata[1:0];
   assign now_ms     = req_tdata[33:2];

   always_comb begin
      case (line_value)
         2'd0:       level_cls = LVL_LOW;
         2'd1:       level_cls = LVL_HIGH;
         default:    level_cls = LVL_ERR;   // both error codes
      endcase
   end

   // ---- state
   level_type                      level_ff;
   logic [TW-1:0]                  change_ff;
   logic [bmcd_pkg::COUNT_W-1:0]   rise_ff;
   logic [NC-1:0]                  flags_ff;
   logic [bmcd_pkg::SPAN_W-1:0]    span_ff;

   assign edge_seen = !clr_cmd && (level_cls != level_ff);

   // ---- edge history: cell 0 is the latest previous edge
   bmcd_pkg::cell_ctl_type cell_ctl;
   logic [TW-1:0]          cell_time [NE];

   assign cell_ctl.shift = req_fire && edge_seen;
   assign cell_ctl.clear = req_fire && clr_cmd;

   for (genvar i = 0; i < NE; i++) begin : g_cell
      logic [TW-1:0] feed;
      if (i == 0) begin : g_head
         assign feed = now_ms;
      end else begin : g_link
         assign feed = cell_time[i-1];
      end
      bmcd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .time_in  (feed),
         .time_out (cell_time[i])
      );
   end

   // ---- window check: k-click pairs with the edge 2k-1 back (cell 2k-2)
   logic [NC-1:0] hits;
   for (genvar k = 0; k < NC; k++) begin : g_tap
      logic [TW-1:0] age;
      assign age     = now_ms - cell_time[2*k];
      assign hits[k] = (cell_time[2*k] != '0) && (age < {{(TW-16){1'b0}}, span_ff});
   end

   // ---- next state and response
   level_type                     level_in;
   logic [TW-1:0]                 change_in;
   logic [bmcd_pkg::COUNT_W-1:0]  rise_in;
   logic [NC-1:0]                 flags_in;
   logic [TW-1:0]                 hold_in;

   always_comb begin
      level_in  = level_ff;
      change_in = change_ff;
      rise_in   = rise_ff;
      flags_in  = flags_ff;
      if (clr_cmd) begin
         flags_in = '0;
      end else if (edge_seen) begin
         level_in  = level_cls;
         change_in = now_ms;
         flags_in  = flags_ff | hits;
         if (level_cls == LVL_HIGH) begin
            rise_in = rise_ff + 1'b1;
         end
      end
      hold_in = now_ms - change_in;
   end

   logic        rsp_valid_ff;
   logic [55:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= LVL_LOW;
         change_ff    <= '0;
         rise_ff      <= '0;
         flags_ff     <= '0;
         span_ff      <= 16'd400;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            span_ff <= csr_data;
         end
         if (req_fire) begin
            level_ff     <= level_in;
            change_ff    <= change_in;
            rise_ff      <= rise_in;
            flags_ff     <= flags_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {1'b0, hold_in, rise_in, flags_in, level_in};
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // ---- checks
   a_clear_empties_flags: assert property (@(posedge clock) disable iff (reset)
      req_fire && clr_cmd |=> (rsp_tdata[6:2] == '0) && (cell_time[0] == '0))
      else $error("flags or history not cleared");

   a_flags_sticky: assert property (@(posedge clock)
      !reset && !(req_fire && clr_cmd) |=> ((flags_ff & $past(flags_ff)) == $past(flags_ff)))
      else $error("click flag dropped without clear");

   a_count_only_on_accept: assert property (@(posedge clock)
      !reset && !req_fire |=> $stable(rise_ff) && $stable(level_ff))
      else $error("state changed without accepted request");

   a_history_moves_on_edge: assert property (@(posedge clock)
      !reset && !req_fire |=> $stable(cell_time[0]))
      else $error("edge history shifted without request");

endmodule

/* rtl/bmcd_cell.sv */
// ----------------------------------------------------------------------------
// bmcd_cell: one stage of the edge-time history line
// Holds one edge timestamp, loads from its neighbor on an edge, zeroes on clear.
// ----------------------------------------------------------------------------
module bmcd_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  bmcd_pkg::cell_ctl_type      ctl,
   input  logic [bmcd_pkg::TIME_W-1:0] time_in,
   output logic [bmcd_pkg::TIME_W-1:0] time_out
);

   logic [bmcd_pkg::TIME_W-1:0] time_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         time_ff <= '0;   // zero = empty slot
      end else if (ctl.shift) begin
         time_ff <= time_in;
      end
   end

   assign time_out = time_ff;

endmodule

/* dv/tb_button_multi_click_detector.sv */
// ----------------------------------------------------------------------------
// tb_button_multi_click_detector: self-checking bench for the click detector
// A scoreboard predicts the response to every accepted request: edge history,
// press count, sticky click flags and hold time. The bench runs a directed
// pass, then randomized click bursts mixed with noise and clears at several
// span settings. Gaps on both channels are random, except in one full-rate phase.
// ----------------------------------------------------------------------------
module tb_button_multi_click_detector;

   localparam int TIME_W        = bmcd_pkg::TIME_W;
   localparam int SPAN_W        = bmcd_pkg::SPAN_W;
   localparam int COUNT_W       = bmcd_pkg::COUNT_W;
   localparam int CLICKS        = bmcd_pkg::MAX_CLICKS;
   localparam int HISTORY_SLOTS = 16;     // ring depth of the edge history
   localparam int DRAIN_CYCLES  = 4;      // response lands in the cycle after accept
   localparam int CYCLE_LIMIT   = 300000; // several times the slowest clean run
   localparam int PHASE_ITEMS   = 80;

   typedef enum logic [0:0] {CMD_SAMPLE = 1'b0, CMD_CLEAR = 1'b1} click_cmd_type;
   typedef enum logic [1:0] {LEVEL_LOW = 2'd0, LEVEL_HIGH = 2'd1, LEVEL_ERROR = 2'd2}
      click_level_type;

   // rsp_tdata[54:0], last member in the lowest bits
   typedef struct packed {
      logic [TIME_W-1:0]        hold_ms;
      logic [COUNT_W-1:0]       press_count;
      logic [CLICKS-1:0]        click_flags;
      logic [1:0]               level_now;
   } click_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: holds its own copy of the detector state and the span.
   // -------------------------------------------------------------------------
   class click_scoreboard;
      logic [TIME_W-1:0]        edge_ms[HISTORY_SLOTS];
      int unsigned              slot;
      click_level_type          last_level;
      logic [TIME_W-1:0]        change_ms;
      logic [COUNT_W-1:0]       presses;
      logic [CLICKS-1:0]        flags;
      logic [SPAN_W-1:0]        span;
      click_result_type         expected[$];
      int                       errors;

      function new();
         foreach (edge_ms[i]) edge_ms[i] = '0;
         slot       = 0;
         last_level = LEVEL_LOW;
         change_ms  = '0;
         presses    = '0;
         flags      = '0;
         span       = 16'd400;
         errors     = 0;
      endfunction

      function void set_span(logic [SPAN_W-1:0] value);
         span = value;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      function void note_request(click_cmd_type cmd, logic [1:0] line,
                                 logic [TIME_W-1:0] now_ms);
         click_level_type   lvl;
         int unsigned       pair;
         logic [TIME_W-1:0] past;
         logic [TIME_W-1:0] delta;
         click_result_type  res;
         if (cmd == CMD_CLEAR) begin
            foreach (edge_ms[i]) edge_ms[i] = '0;
            slot  = 0;
            flags = '0;
         end else begin
            lvl = (line == 2'd0) ? LEVEL_LOW : (line == 2'd1) ? LEVEL_HIGH : LEVEL_ERROR;
            if (lvl != last_level) begin
               change_ms     = now_ms;
               last_level    = lvl;
               edge_ms[slot] = now_ms;
               if (lvl == LEVEL_HIGH) presses = presses + 1'b1;
               // k-click: edge 2k-1 back, nonzero, inside the span window
               for (int k = 0; k < CLICKS; k++) begin
                  pair  = (slot + HISTORY_SLOTS - (2 * k + 1)) % HISTORY_SLOTS;
                  past  = edge_ms[pair];
                  delta = now_ms - past;
                  if (past != '0 && delta < {16'd0, span}) flags[k] = 1'b1;
               end
               slot = (slot + 1) % HISTORY_SLOTS;
            end
         end
         res.level_now   = last_level;
         res.click_flags = flags;
         res.press_count = presses;
         res.hold_ms     = now_ms - change_ms;
         expected.push_back(res);
      endfunction

      function void check_response(click_result_type got);
         click_result_type exp;
         if (expected.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         exp = expected.pop_front();
         if (got.level_now !== exp.level_now) begin
            $error("level_now expected %0d got %0d", exp.level_now, got.level_now);
            errors++;
         end
         if (got.click_flags !== exp.click_flags) begin
            $error("click_flags expected %b got %b", exp.click_flags, got.click_flags);
            errors++;
         end
         if (got.press_count !== exp.press_count) begin
            $error("press_count expected %0d got %0d", exp.press_count, got.press_count);
            errors++;
         end
         if (got.hold_ms !== exp.hold_ms) begin
            $error("hold_ms expected %0d got %0d", exp.hold_ms, got.hold_ms);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [0:0]  req_tuser;   // [0] cmd
   logic [39:0] req_tdata;   // [1:0] line_value, [33:2] now_ms, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // [1:0] level_now, [6:2] click_flags,
                             // [22:7] press_count, [54:23] hold_ms
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;    // span_ms

   button_multi_click_detector i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   click_scoreboard   clicks = new();
   logic              gaps_on;     // idle/stall enable, both channels
   logic [TIME_W-1:0] clock_ms;    // running button time base for bursts
   int                cycles;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // hard stop if the bench hangs
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[button_multi_click_detector] ERROR");
         $finish;
      end
   end

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // response side: random stalls on rsp_tready
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) clicks.check_response(rsp_tdata[54:0]);
   end

   // -------------------------------------------------------------------------
   // Driver tasks. Each is entered and left just after a falling edge; a
   // request that is still valid must be replaced or dropped at that edge.
   // -------------------------------------------------------------------------
   task automatic send_request(click_cmd_type cmd, logic [1:0] line,
                               logic [TIME_W-1:0] now_ms);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, now_ms, line};
      do @(posedge clock); while (!req_tready);
      clicks.note_request(cmd, line, now_ms);
      @(negedge clock);
   endtask

   // stop sending and let every outstanding response come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (clicks.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_span(logic [SPAN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      clicks.set_span(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [TIME_W-1:0] click_step();
      // mostly well inside a 400 ms window, sometimes straddling it
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 120);
      return $urandom_range(100, 700);
   endfunction

   // click bursts with random timing, plus noise, clears and time jumps
   task automatic random_clicks(int n_items);
      int         sent;
      int         r;
      int         presses;
      logic       drained;
      logic [1:0] release_line;
      sent    = 0;
      drained = 1'b0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_request(CMD_CLEAR, 2'($urandom_range(0, 3)), $urandom());
            sent++;
         end else if (r < 18) begin
            // noise: any reading, any time
            send_request(CMD_SAMPLE, 2'($urandom_range(0, 3)),
                         $urandom_range(0, 1) ? $urandom() : clock_ms + $urandom_range(0, 50));
            sent++;
         end else if (r < 21) begin
            // jump the time base, sometimes just short of the wrap
            clock_ms = $urandom();
            if ($urandom_range(0, 1)) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
         end else begin
            presses = $urandom_range(1, 6);
            for (int p = 0; p < presses; p++) begin
               clock_ms += click_step();
               send_request(CMD_SAMPLE, 2'd1, clock_ms);
               sent++;
               if ($urandom_range(0, 4) == 0) begin
                  // held sample, no edge
                  clock_ms += $urandom_range(0, 30);
                  send_request(CMD_SAMPLE, 2'd1, clock_ms);
                  sent++;
               end
               clock_ms += click_step();
               release_line = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'd0;
               send_request(CMD_SAMPLE, release_line, clock_ms);
               sent++;
            end
            clock_ms += $urandom_range(0, 2000);
         end
         // halfway through, hold off until the detector has caught up
         if (!drained && sent >= n_items / 2) begin
            wait_drained();
            drained = 1'b1;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [SPAN_W-1:0] spans[5];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      gaps_on    = 1'b1;
      clock_ms   = 32'd5000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass at the reset span of 400 ms
      send_request(CMD_SAMPLE, 2'd0, 32'd100);         // no edge, hold from reset
      send_request(CMD_SAMPLE, 2'd1, 32'd0);           // edge stamped at time zero
      send_request(CMD_SAMPLE, 2'd0, 32'd50);          // partner is the empty-looking slot
      send_request(CMD_SAMPLE, 2'd1, 32'd120);         // single click
      send_request(CMD_SAMPLE, 2'd0, 32'd200);
      send_request(CMD_SAMPLE, 2'd1, 32'd260);         // double click
      send_request(CMD_SAMPLE, 2'd2, 32'd300);         // error level is an edge
      send_request(CMD_SAMPLE, 2'd3, 32'd310);         // same error level, no edge
      send_request(CMD_CLEAR, 2'd1, 32'd320);          // line ignored on clear
      send_request(CMD_SAMPLE, 2'd1, 32'hFFFF_FFF0);
      send_request(CMD_SAMPLE, 2'd0, 32'h0000_0010);   // window across the time wrap
      send_request(CMD_CLEAR, 2'd3, 32'hFFFF_FFFF);
      for (int i = 0; i < 10; i++)                     // ten fast edges: up to 5-click
         send_request(CMD_SAMPLE, (i % 2 == 0) ? 2'd1 : 2'd0, 32'(1000 + 10 * i));
      wait_drained();

      // random phases across span settings, extremes included
      spans[0] = 16'd0;
      spans[1] = 16'hFFFF;
      spans[2] = 16'd1;
      spans[3] = 16'd400;
      spans[4] = 16'($urandom_range(50, 1000));
      foreach (spans[i]) begin
         gaps_on = (i != 2);   // one phase runs at full rate on both sides
         write_span(spans[i]);
         random_clicks(PHASE_ITEMS);
         wait_drained();
      end

      if (clicks.errors == 0) begin
         $display("[button_multi_click_detector] OK");
      end else begin
         $display("[button_multi_click_detector] ERROR");
      end
      $finish;
   end

endmodule
